/* rtl/core/float_run_length_histogram_defines.svh */
// Assertion macros for the float run-length histogram.
`ifndef FLOAT_RUN_LENGTH_HISTOGRAM_DEFINES_SVH
`define FLOAT_RUN_LENGTH_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FRLH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define FRLH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/frlh_pkg.sv */
// Package for the float run-length histogram: sizes, codes and limits.
package frlh_pkg;

  localparam int MAX_LINE_LENGTH = 256;
  localparam int ADDR_W          = $clog2(MAX_LINE_LENGTH);
  localparam int LEN_W           = 9;
  localparam int CNT_W           = 32;
  localparam int CFG_AW          = 3;
  localparam int CFG_DW          = 32;
  localparam int IN_DATA_W       = 16;
  localparam int OUT_DATA_W      = 112;

  localparam logic [CNT_W-1:0] SAT_CNT  = {CNT_W{1'b1}};
  localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_LINE_LENGTH);

  // register index taken from paddr[2]
  localparam logic REG_FLOAT_LEVEL = 1'b0;

  typedef enum logic [1:0] {
    KIND_CELL  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

endpackage

/* rtl/core/float_run_length_histogram.sv */
// Top level of the float run-length histogram.
//
// Float run-length histogram. Cells of a weave matrix stream in one word at a time
// (kind = cell), line by line, with in_tlast on the last cell of each line. Runs of
// cells at the level chosen by register float_level (0 lowered, 1 raised) are measured
// and closed on a level change or at line end; every closed run bumps its length bin
// and updates the run count, the longest run and the summed run cells, all saturating.
// Overlong runs count as MAX_LINE_LENGTH. A read word (kind = read) returns one bin in
// bin_count, a clear word zeroes all statistics and drops an open run. Every input word
// yields exactly one output word carrying the statistics after that word.
// Timing: one word per clock sustained while out_tready stays high; each word passes
// the update stage and then the output register, and a held result stalls the input.
// The run tracker works in the accept cycle and issues the bin read to a single 256 x 32
// histogram RAM; the next stage adds, writes back and loads the output register. A bin
// written in one cycle and read in the same cycle is forwarded. Clear needs no pass
// over the RAM (per-bin valid flags drop at once), and no clearing pass follows reset.
// float_level is written over the APB port at byte address 0 and applies from the
// next cell; write it only while the block is idle.
`include "float_run_length_histogram_defines.svh"

module float_run_length_histogram
  import frlh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [0] cell_raised, [9:1] bin_index, rest zero
  input  logic                  in_tlast,   // end_of_line
  input  logic [1:0]            in_tuser,   // [1:0] kind
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [31:0] bin_count, [63:32] run_total,
                                            // [72:64] longest_run, [104:73] run_cells
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [CFG_DW-1:0]     cfg_pwdata,
  output logic [CFG_DW-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  // ---------------- configuration ----------------
  logic float_level_r;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      float_level_r <= 1'b0;
    end else if (cfg_wr && (cfg_paddr[2] == REG_FLOAT_LEVEL)) begin
      float_level_r <= cfg_pwdata[0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_FLOAT_LEVEL) begin
      cfg_prdata = CFG_DW'(float_level_r);
    end
  end

  // ---------------- state ----------------
  logic [CNT_W-1:0]           hist_mem [MAX_LINE_LENGTH];
  logic [MAX_LINE_LENGTH-1:0] bin_vld_r;     // bin holds a written value
  logic                       in_run_r;
  logic [LEN_W-1:0]           cur_len_r;
  logic [CNT_W-1:0]           runs_r;
  logic [LEN_W-1:0]           longest_r;
  logic [CNT_W-1:0]           cells_r;

  // second stage
  logic              s1_valid_r;
  logic              s1_close_r;
  logic              s1_clear_r;
  logic              s1_read_r;
  logic [LEN_W-1:0]  s1_len_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [CNT_W-1:0]  mem_q_r;
  logic              q_vld_r;                // entry was valid when read
  logic              fwd_hit_r;              // same bin written in the read cycle
  logic [CNT_W-1:0]  fwd_val_r;
  logic              q_zero_r;               // clear retired in the read cycle

  logic              out_valid_r;
  logic [CNT_W-1:0]  out_bin_r;

  // ---------------- accept stage ----------------
  kind_t             kind;
  logic              cell_raised;
  logic [LEN_W-1:0]  bin_index;
  logic              in_accept;
  logic              s1_fire;
  logic              match;
  logic [LEN_W-1:0]  len_ext;
  logic              close0;
  logic [LEN_W-1:0]  close_len0;
  logic              read_ok0;
  logic [ADDR_W-1:0] rd_addr;
  logic              in_run_nxt;
  logic [LEN_W-1:0]  cur_len_nxt;

  assign kind        = kind_t'(in_tuser);
  assign cell_raised = in_tdata[0];
  assign bin_index   = in_tdata[LEN_W:1];

  // stage 1 retires unless its result cannot be placed
  assign s1_fire   = s1_valid_r && !(out_valid_r && !out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_accept = in_tvalid && in_tready;

  assign match   = (cell_raised == float_level_r);
  assign len_ext = (cur_len_r < MAX_LEN) ? LEN_W'(cur_len_r + LEN_W'(1)) : cur_len_r;

  always_comb begin
    close0      = 1'b0;
    close_len0  = cur_len_r;
    read_ok0    = 1'b0;
    in_run_nxt  = in_run_r;
    cur_len_nxt = cur_len_r;
    unique case (kind)
      KIND_CELL: begin
        if (match) begin
          // extend, then a line end closes the extended run
          close_len0 = len_ext;
          close0     = in_tlast;
          in_run_nxt  = !in_tlast;
          cur_len_nxt = in_tlast ? '0 : len_ext;
        end else if (in_run_r) begin
          close0      = (cur_len_r != '0);
          in_run_nxt  = 1'b0;
          cur_len_nxt = '0;
        end
      end
      KIND_READ: begin
        read_ok0 = (bin_index != '0) && (bin_index <= MAX_LEN);
      end
      KIND_CLEAR: begin
        in_run_nxt  = 1'b0;
        cur_len_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (close0) begin
      rd_addr = close_len0[ADDR_W-1:0] - ADDR_W'(1);
    end else begin
      rd_addr = bin_index[ADDR_W-1:0] - ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r  <= 1'b0;
      cur_len_r <= '0;
    end else if (in_accept) begin
      in_run_r  <= in_run_nxt;
      cur_len_r <= cur_len_nxt;
    end
  end

  // ---------------- update stage ----------------
  logic [CNT_W-1:0] bin_cur;
  logic [CNT_W-1:0] bin_inc;
  logic [CNT_W:0]   cells_sum;
  logic [CNT_W-1:0] runs_nxt;
  logic [LEN_W-1:0] longest_nxt;
  logic [CNT_W-1:0] cells_nxt;
  logic             wr_en;

  always_comb begin
    priority if (q_zero_r) begin
      bin_cur = '0;
    end else if (fwd_hit_r) begin
      bin_cur = fwd_val_r;
    end else if (q_vld_r) begin
      bin_cur = mem_q_r;
    end else begin
      bin_cur = '0;
    end
  end

  assign bin_inc   = (bin_cur == SAT_CNT) ? SAT_CNT : CNT_W'(bin_cur + CNT_W'(1));
  assign cells_sum = {1'b0, cells_r} + (CNT_W + 1)'(s1_len_r);
  assign wr_en     = s1_fire && s1_close_r;

  always_comb begin
    runs_nxt    = runs_r;
    longest_nxt = longest_r;
    cells_nxt   = cells_r;
    priority if (s1_clear_r) begin
      runs_nxt    = '0;
      longest_nxt = '0;
      cells_nxt   = '0;
    end else if (s1_close_r) begin
      runs_nxt    = (runs_r == SAT_CNT) ? SAT_CNT : CNT_W'(runs_r + CNT_W'(1));
      longest_nxt = (s1_len_r > longest_r) ? s1_len_r : longest_r;
      cells_nxt   = cells_sum[CNT_W] ? SAT_CNT : cells_sum[CNT_W-1:0];
    end
  end

  // histogram RAM: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[s1_addr_r] <= bin_inc;
    end
    if (in_accept) begin
      mem_q_r <= hist_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_vld_r <= '0;
    end else if (s1_fire && s1_clear_r) begin
      bin_vld_r <= '0;
    end else if (wr_en) begin
      bin_vld_r[s1_addr_r] <= 1'b1;
    end
  end

  // read-side bypass of the write and clear retiring in the same cycle
  always_ff @(posedge clk) begin
    if (in_accept) begin
      q_vld_r   <= bin_vld_r[rd_addr];
      fwd_hit_r <= wr_en && (s1_addr_r == rd_addr);
      fwd_val_r <= bin_inc;
      q_zero_r  <= s1_fire && s1_clear_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_close_r <= close0;
      s1_clear_r <= (kind == KIND_CLEAR);
      s1_read_r  <= read_ok0;
      s1_len_r   <= close_len0;
      s1_addr_r  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      runs_r    <= '0;
      longest_r <= '0;
      cells_r   <= '0;
    end else if (s1_fire) begin
      runs_r    <= runs_nxt;
      longest_r <= longest_nxt;
      cells_r   <= cells_nxt;
    end
  end

  // ---------------- output register ----------------
  // statistics only move on s1_fire, which also loads a fresh word, so the
  // output reads them directly
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_bin_r <= s1_read_r ? bin_cur : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, cells_r, longest_r, runs_r, out_bin_r};

  // ---------------- assertions ----------------
  `FRLH_ASSERT_NOW(a_no_accept_on_stall, s1_valid_r && out_valid_r && !out_tready,
                   !in_tready, "input accepted while update stage is stalled")
  `FRLH_ASSERT_NEXT(a_fire_loads_out, s1_fire, out_valid_r,
                    "retired word did not reach the output")
  `FRLH_ASSERT_NOW(a_longest_bound, 1'b1, longest_r <= MAX_LEN,
                   "longest run beyond line limit")
  `FRLH_ASSERT_NEXT(a_clear_zeroes, s1_fire && s1_clear_r,
                    (runs_r == '0) && (cells_r == '0) && (bin_vld_r == '0),
                    "clear left statistics behind")

endmodule

/* tb/float_run_length_histogram_tb.sv */
// Testbench for float_run_length_histogram: directed table, then random cell streams.
`timescale 1ns / 100ps

module float_run_length_histogram_tb;
  import frlh_pkg::*;

  // Testbench-only names: the spare kind code and the kinds of directed row.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 4;     // update stage and output register plus margin
  localparam int STALL_LIMIT   = 2000;  // cycles without any handshake
  localparam logic [CFG_AW-1:0] FLOAT_LEVEL_ADDR = {REG_FLOAT_LEVEL, 2'b00};

  typedef enum logic {ROW_WORD, ROW_LEVEL} row_op_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       raised;
    logic       eol;
    logic [8:0] idx;
  } cell_word_t;

  typedef struct packed {
    logic [31:0] bin_count;
    logic [31:0] run_total;
    logic [8:0]  longest_run;
    logic [31:0] run_cells;
  } run_stats_t;

  typedef struct {
    row_op_t    op;
    cell_word_t w;
    int         reps;
    logic       known;   // result typed into the table
    run_stats_t want;
    logic       level;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;  // [0] cell_raised, [9:1] bin_index
  logic                  in_tlast    = 1'b0;  // end_of_line
  logic [1:0]            in_tuser    = '0;  // [1:0] kind
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;   // [31:0] bin_count, [63:32] run_total,
                                      // [72:64] longest_run, [104:73] run_cells
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]     cfg_paddr   = '0;
  logic [CFG_DW-1:0]     cfg_pwdata  = '0;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  float_run_length_histogram i_dut (.*);

  // ---------------------------------------------------------------------------
  // Run tracker shadow: configuration, open run and statistics
  // ---------------------------------------------------------------------------
  logic        level_q;
  logic        run_open;
  logic [8:0]  run_len;
  logic [31:0] length_bins [1:MAX_LINE_LENGTH];
  logic [31:0] runs_total;
  logic [8:0]  longest;
  logic [31:0] cell_sum;

  run_stats_t  pending_stats [$];  // results owed by the block, oldest first
  int          error_count = 0;
  int          idle_pct    = 23;   // percent of cycles each side holds off

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? SAT_CNT : s[31:0];
  endfunction

  task automatic clear_stats();
    for (int i = 1; i <= MAX_LINE_LENGTH; i++) length_bins[i] = '0;
    runs_total = '0;
    longest    = '0;
    cell_sum   = '0;
    run_open   = 1'b0;
    run_len    = '0;
  endtask

  // Close the open run: bump its bin and the three saturating statistics.
  task automatic close_run();
    if (run_open && run_len != '0) begin
      length_bins[run_len] = sat_add(length_bins[run_len], 32'd1);
      runs_total = sat_add(runs_total, 32'd1);
      cell_sum   = sat_add(cell_sum, 32'(run_len));
      if (run_len > longest) longest = run_len;
    end
    run_open = 1'b0;
    run_len  = '0;
  endtask

  // Apply one accepted word and return the result word it should produce.
  task automatic track_word(input cell_word_t w, output run_stats_t r);
    r.bin_count = '0;
    case (w.kind)
      KIND_CELL: begin
        // the cell extends or closes first, the line end closes after that
        if (w.raised == level_q) begin
          run_open = 1'b1;
          if (run_len < MAX_LEN) run_len = run_len + 1'b1;
        end else if (run_open) begin
          close_run();
        end
        if (w.eol && run_open) close_run();
      end
      KIND_READ: begin
        if (w.idx >= 1 && w.idx <= MAX_LINE_LENGTH) r.bin_count = length_bins[w.idx];
      end
      KIND_CLEAR: clear_stats();
      default: ;  // spare kind: nothing changes
    endcase
    r.run_total   = runs_total;
    r.longest_run = longest;
    r.run_cells   = cell_sum;
  endtask

  task automatic log_error(input string msg);
    $display("%0t ns  mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset, result-side stalls
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Result check: every result word against the oldest pending expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    run_stats_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.bin_count   = out_tdata[31:0];
      got.run_total   = out_tdata[63:32];
      got.longest_run = out_tdata[72:64];
      got.run_cells   = out_tdata[104:73];
      if (pending_stats.size() == 0) begin
        log_error("result word with nothing pending");
      end else begin
        want = pending_stats.pop_front();
        if (got.bin_count !== want.bin_count)
          log_error($sformatf("bin_count %0d, want %0d", got.bin_count, want.bin_count));
        if (got.run_total !== want.run_total)
          log_error($sformatf("run_total %0d, want %0d", got.run_total, want.run_total));
        if (got.longest_run !== want.longest_run)
          log_error($sformatf("longest_run %0d, want %0d",
                              got.longest_run, want.longest_run));
        if (got.run_cells !== want.run_cells)
          log_error($sformatf("run_cells %0d, want %0d", got.run_cells, want.run_cells));
      end
    end
  end

  // Watchdog: a long run of cycles without a handshake on either stream ends it.
  always @(posedge clk) begin
    int quiet_cycles;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("float_run_length_histogram_tb: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Offer one word, hold it until taken, then log what it should return.
  // tvalid is only lowered in idle cycles, so back-to-back words keep it high.
  task automatic send_word(input cell_word_t w, input logic known, input run_stats_t want);
    run_stats_t calc;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= w.kind;
    in_tlast  <= w.eol;
    in_tdata  <= IN_DATA_W'({w.idx, w.raised});
    do @(posedge clk); while (!in_tready);
    track_word(w, calc);
    pending_stats.push_back(known ? want : calc);
  endtask

  // Stop the stream and let every owed result come out, plus the pipe depth.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write float_level while idle (setup then access), then read it back.
  task automatic set_float_level(input logic lvl);
    drain();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= FLOAT_LEVEL_ADDR;
    cfg_pwdata  <= CFG_DW'(lvl);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    level_q = lvl;  // register taken at this edge
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== CFG_DW'(lvl))
      log_error($sformatf("float_level reads %0h, want %0h", cfg_prdata, lvl));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic plan_row_t word_row(input logic [1:0] kind, input logic raised,
                                         input logic eol, input logic [8:0] idx,
                                         input int reps);
    plan_row_t r;
    r.op    = ROW_WORD;
    r.w     = '{kind: kind, raised: raised, eol: eol, idx: idx};
    r.reps  = reps;
    r.known = 1'b0;
    r.want  = '0;
    r.level = 1'b0;
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic [1:0] kind, input logic raised,
                                          input logic eol, input logic [8:0] idx,
                                          input run_stats_t want);
    plan_row_t r;
    r       = word_row(kind, raised, eol, idx, 1);
    r.known = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic plan_row_t level_row(input logic lvl);
    plan_row_t r;
    r       = word_row(KIND_CELL, 1'b0, 1'b0, '0, 0);
    r.op    = ROW_LEVEL;
    r.level = lvl;
    return r;
  endfunction

  // Random words: mostly short lines with runs in them, then reads, and a
  // little noise (clears, spare kinds, stray cells). Spare kinds do not count.
  // A line is cut short where the word budget runs out.
  task automatic random_phase(input int n_words);
    int         sent;
    int         roll;
    int         line_len;
    int         c;
    logic       lvl;
    cell_word_t w;
    sent = 0;
    while (sent < n_words) begin
      roll  = $urandom_range(99);
      w.idx = 9'($urandom);
      if (roll < 70) begin
        line_len = $urandom_range(12, 1);
        if (line_len > n_words - sent) line_len = n_words - sent;
        lvl = 1'($urandom_range(1));
        for (c = 0; c < line_len; c++) begin
          if ($urandom_range(99) < 35) lvl = ~lvl;
          w.kind   = KIND_CELL;
          w.raised = lvl;
          w.eol    = (c == line_len - 1);
          w.idx    = 9'($urandom);
          send_word(w, 1'b0, '0);
          sent++;
        end
      end else if (roll < 90) begin
        w.kind   = KIND_READ;
        w.raised = 1'($urandom_range(1));
        w.eol    = 1'($urandom_range(1));
        if ($urandom_range(3) != 0) w.idx = 9'($urandom_range(16, 1));
        send_word(w, 1'b0, '0);
        sent++;
      end else if (roll < 93) begin
        w.kind   = KIND_CLEAR;
        w.raised = 1'($urandom_range(1));
        w.eol    = 1'($urandom_range(1));
        send_word(w, 1'b0, '0);
        sent++;
      end else if (roll < 96) begin
        w.kind   = KIND_UNUSED;
        w.raised = 1'($urandom_range(1));
        w.eol    = 1'($urandom_range(1));
        send_word(w, 1'b0, '0);
      end else begin
        // stray cell, line end at random
        w.kind   = KIND_CELL;
        w.raised = 1'($urandom_range(1));
        w.eol    = 1'($urandom_range(1));
        send_word(w, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t plan [$];

    level_q = 1'b0;
    clear_stats();

    // Directed table. Level 0 first: lowered cells are floats.
    plan.push_back(level_row(1'b0));
    plan.push_back(known_row(KIND_READ,   1'b0, 1'b0, 9'd1,   '0));  // empty after reset
    plan.push_back(known_row(KIND_UNUSED, 1'b1, 1'b1, 9'd511, '0));  // spare kind
    plan.push_back(known_row(KIND_READ,   1'b0, 1'b0, 9'd0,   '0));  // bin 0 is out of range
    plan.push_back(word_row(KIND_CELL, 1'b0, 1'b0, 9'd0, 2));        // run of two...
    plan.push_back(word_row(KIND_CELL, 1'b1, 1'b0, 9'd0, 1));        // ...closed by level
    plan.push_back(word_row(KIND_CELL, 1'b0, 1'b1, 9'd0, 1));        // extend, then line end
    plan.push_back(word_row(KIND_CELL, 1'b1, 1'b1, 9'd0, 1));        // line end, no run
    plan.push_back(word_row(KIND_READ, 1'b0, 1'b0, 9'd2, 1));
    plan.push_back(word_row(KIND_READ, 1'b0, 1'b0, 9'd1, 1));
    plan.push_back(known_row(KIND_READ, 1'b0, 1'b0, 9'd257,
                             run_stats_t'{32'd0, 32'd2, 9'd2, 32'd3}));
    // overlong line: the run pins at the ceiling and lands in the top bin
    plan.push_back(word_row(KIND_CELL, 1'b0, 1'b0, 9'd0, 299));
    plan.push_back(word_row(KIND_CELL, 1'b0, 1'b1, 9'd0, 1));
    plan.push_back(known_row(KIND_READ, 1'b0, 1'b0, 9'd256,
                             run_stats_t'{32'd1, 32'd3, 9'd256, 32'd259}));
    plan.push_back(known_row(KIND_READ, 1'b1, 1'b1, 9'd511,
                             run_stats_t'{32'd0, 32'd3, 9'd256, 32'd259}));
    // clear drops the open run as well
    plan.push_back(word_row(KIND_CELL, 1'b0, 1'b0, 9'd0, 1));
    plan.push_back(known_row(KIND_CLEAR, 1'b0, 1'b0, 9'd0, '0));
    plan.push_back(word_row(KIND_CELL, 1'b0, 1'b1, 9'd0, 1));
    plan.push_back(word_row(KIND_READ, 1'b0, 1'b0, 9'd1, 1));
    // level flips with a run open: the run keeps counting under the new level
    plan.push_back(word_row(KIND_CELL, 1'b0, 1'b0, 9'd0, 3));
    plan.push_back(level_row(1'b1));
    plan.push_back(word_row(KIND_CELL, 1'b1, 1'b0, 9'd0, 1));
    plan.push_back(word_row(KIND_CELL, 1'b0, 1'b1, 9'd0, 1));
    plan.push_back(word_row(KIND_READ, 1'b0, 1'b0, 9'd4, 1));
    plan.push_back(word_row(KIND_CELL, 1'b1, 1'b1, 9'd0, 2));        // one-cell lines
    plan.push_back(word_row(KIND_READ, 1'b1, 1'b1, 9'd1, 1));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].op == ROW_LEVEL) begin
        set_float_level(plan[i].level);
      end else begin
        repeat (plan[i].reps) send_word(plan[i].w, plan[i].known, plan[i].want);
      end
    end

    // Random phases, level flipping between them; phase 2 is the longer
    // stretch without idling.
    for (int p = 0; p < 4; p++) begin
      set_float_level(p[0]);
      idle_pct = (p == 2) ? 0 : 23;
      random_phase((p == 2) ? 30 : 15);
    end
    idle_pct = 23;

    drain();
    if (error_count == 0 && pending_stats.size() == 0) begin
      $display("float_run_length_histogram_tb: clean");
    end else begin
      $display("float_run_length_histogram_tb: errors");
    end
    $finish;
  end

endmodule

/* float_run_length_histogram.f */
+incdir+rtl/core
rtl/core/frlh_pkg.sv
rtl/core/float_run_length_histogram.sv
tb/float_run_length_histogram_tb.sv
